// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checking code of the filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/mdnf_pkg.sv =====
// Shared types and constants of the minimum-distance neighbor filter.
package mdnf_pkg;
    localparam int MAX_NEIGHBORS = 64;
    localparam int IDX_W = $clog2(MAX_NEIGHBORS);
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam logic [31:0] SELF_SUBST = 32'd655294464; // 9999 << 16
    localparam logic [17:0] TOL_RESET = 18'd6554;
    localparam logic [0:0] ADDR_TOL = 1'b0;
    localparam logic [0:0] ADDR_MODE = 1'b1;

    // Group summary passed from the loader to the emitter.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [31:0]      min_d2;
        logic             ovf;
    } group_t;

    typedef struct packed {
        logic [15:0] site;
        logic [7:0]  ia;
        logic [7:0]  ib;
        logic [7:0]  ic;
        logic [23:0] weight;
        logic        valid_nb;
        logic        ovf;
        logic        last;
    } result_t;

    typedef enum logic [3:0] {
        EM_IDLE, EM_READ, EM_WAIT, EM_TEST, EM_DIV, EM_SQRT, EM_PUSH, EM_EMPTY, EM_DONE
    } em_state_t;
endpackage

// ===== rtl/mdnf_loader.sv =====
// Front part: stores entries of a group and tracks minimum and overflow.
module mdnf_loader (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [71:0]         in_word,
    input  logic                in_last,
    output logic                wr_en,
    output logic [mdnf_pkg::IDX_W-1:0] wr_addr,
    output logic [71:0]         wr_word,
    output logic                grp_valid,
    output mdnf_pkg::group_t    grp,
    input  logic                grp_take
);
    logic [mdnf_pkg::CNT_W-1:0] count_reg;
    logic [31:0] min_reg;
    logic ovf_reg;
    logic pend_reg;
    logic [31:0] d2, eff;
    logic fire, room;

    assign in_ready = !pend_reg;
    assign fire = in_valid && in_ready;
    assign d2 = in_word[71:40];
    assign eff = (d2 == 32'd0) ? mdnf_pkg::SELF_SUBST : d2;
    assign room = count_reg < mdnf_pkg::CNT_W'(mdnf_pkg::MAX_NEIGHBORS);
    assign wr_en = fire && room;
    assign wr_addr = count_reg[mdnf_pkg::IDX_W-1:0];
    assign wr_word = in_word;
    assign grp_valid = pend_reg;
    assign grp.count = count_reg;
    assign grp.min_d2 = min_reg;
    assign grp.ovf = ovf_reg;

    // Group accumulation; the group is handed over after the last word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg <= '1;
            ovf_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (grp_take)
        begin
            count_reg <= '0;
            min_reg <= '1;
            ovf_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (room)
            begin
                count_reg <= count_reg + 1'b1;
                if (eff < min_reg)
                    min_reg <= eff;
            end
            else
                ovf_reg <= 1'b1;
            if (in_last)
                pend_reg <= 1'b1;
        end
    end
endmodule

// ===== rtl/mdnf_emitter.sv =====
// Back part: threshold test, divide, square root per stored entry; all-sites: root only.
module mdnf_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grp_valid,
    input  mdnf_pkg::group_t    grp,
    output logic                grp_take,
    output logic [mdnf_pkg::IDX_W-1:0] rd_addr,
    input  logic [71:0]         rd_word,
    input  logic [17:0]         tolerance,
    input  logic                all_sites_mode,
    output logic                res_valid,
    output mdnf_pkg::result_t   res,
    input  logic                res_ready
);
    mdnf_pkg::em_state_t state_reg, state_next;
    logic [mdnf_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [71:0] ent_reg;
    logic [39:0] f2_reg;
    logic [63:0] plo_reg;
    logic [71:0] prod_reg;
    logic [63:0] rem_reg, quo_reg, sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [6:0] step_reg;
    logic emitted_reg, emitted_next;
    logic held_reg;
    mdnf_pkg::result_t held_res;
    mdnf_pkg::result_t stage_res_reg;
    mdnf_pkg::result_t push_res;
    logic [18:0] f;
    logic [31:0] d2;
    logic qual, last_idx;
    logic op_load, op_div_init, op_sqrt_init, op_push, op_stage;

    assign f = 19'd65536 + {1'b0, tolerance};
    assign d2 = ent_reg[71:40];
    assign rd_addr = idx_reg[mdnf_pkg::IDX_W-1:0];
    assign last_idx = (idx_reg + 1'b1) >= grp.count;
    // Compare d2 * 2^32 against f^2 * m using the registered product.
    assign qual = ({d2, 32'd0} < prod_reg);

    // Sequencer over the buffered entries.
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        emitted_next = emitted_reg;
        grp_take = 1'b0;
        op_load = 1'b0;
        op_div_init = 1'b0;
        op_sqrt_init = 1'b0;
        op_push = 1'b0;
        op_stage = 1'b0;
        unique case (state_reg)
            mdnf_pkg::EM_IDLE:
                if (grp_valid)
                begin
                    idx_next = '0;
                    emitted_next = 1'b0;
                    state_next = (grp.count == '0) ? mdnf_pkg::EM_EMPTY : mdnf_pkg::EM_READ;
                end
            mdnf_pkg::EM_READ: state_next = mdnf_pkg::EM_WAIT;
            mdnf_pkg::EM_WAIT:
            begin
                op_load = 1'b1;
                state_next = mdnf_pkg::EM_TEST;
            end
            mdnf_pkg::EM_TEST:
                if (d2 == 32'd0 || (!all_sites_mode && !qual))
                begin
                    if (last_idx)
                        state_next = emitted_reg ? mdnf_pkg::EM_DONE : mdnf_pkg::EM_EMPTY;
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = mdnf_pkg::EM_READ;
                    end
                end
                else if (all_sites_mode)
                begin
                    op_sqrt_init = 1'b1;
                    state_next = mdnf_pkg::EM_SQRT;
                end
                else
                begin
                    op_div_init = 1'b1;
                    state_next = mdnf_pkg::EM_DIV;
                end
            mdnf_pkg::EM_DIV:
                if (step_reg == 7'd0)
                begin
                    op_sqrt_init = 1'b1;
                    state_next = mdnf_pkg::EM_SQRT;
                end
            mdnf_pkg::EM_SQRT:
                if (sq_bit_reg == 64'd0)
                    state_next = mdnf_pkg::EM_PUSH;
            mdnf_pkg::EM_PUSH:
                // The previous result leaves the staging register, the new one enters it.
                if (!held_reg)
                begin
                    op_push = emitted_reg;
                    op_stage = 1'b1;
                    emitted_next = 1'b1;
                    if (last_idx)
                        state_next = mdnf_pkg::EM_DONE;
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = mdnf_pkg::EM_READ;
                    end
                end
            mdnf_pkg::EM_EMPTY:
                if (!held_reg)
                begin
                    op_push = 1'b1;
                    state_next = mdnf_pkg::EM_DONE;
                end
            mdnf_pkg::EM_DONE:
                // The staged result, if any, goes out as the last word of the group.
                if (!held_reg)
                begin
                    op_push = emitted_reg;
                    grp_take = 1'b1;
                    state_next = mdnf_pkg::EM_IDLE;
                end
            default: state_next = mdnf_pkg::EM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdnf_pkg::EM_IDLE;
            idx_reg <= '0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            emitted_reg <= emitted_next;
        end
    end

    // Datapath: two-step product, restoring divider and bit-pair square root.
    always_ff @(posedge clk)
    begin
        f2_reg <= 40'(f * f);
        if (state_reg == mdnf_pkg::EM_READ)
            plo_reg <= 64'(f2_reg[31:0] * grp.min_d2);
        if (state_reg == mdnf_pkg::EM_WAIT)
            prod_reg <= {40'(f2_reg[39:32] * grp.min_d2), 32'd0} + {8'd0, plo_reg};
        if (op_load)
            ent_reg <= rd_word;
        if (op_div_init)
        begin
            rem_reg <= '0;
            quo_reg <= {grp.min_d2, 32'd0};
            step_reg <= 7'd64;
        end
        else if (state_reg == mdnf_pkg::EM_DIV && step_reg != 7'd0)
        begin
            if ({rem_reg[62:0], quo_reg[63]} >= {32'd0, d2})
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]} - {32'd0, d2};
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            step_reg <= step_reg - 1'b1;
        end
        if (op_sqrt_init)
        begin
            sq_v_reg <= all_sites_mode ? {16'd0, d2, 16'd0} : quo_reg;
            sq_r_reg <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (state_reg == mdnf_pkg::EM_SQRT && sq_bit_reg != 64'd0)
        begin
            if (sq_v_reg >= sq_r_reg + sq_bit_reg)
            begin
                sq_v_reg <= sq_v_reg - (sq_r_reg + sq_bit_reg);
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
                sq_r_reg <= sq_r_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (op_stage)
            stage_res_reg <= {ent_reg[39:0], sq_r_reg[23:0], 1'b1, grp.ovf, 1'b0};
    end

    // Word handed to the output register.
    always_comb
    begin
        push_res = stage_res_reg;
        push_res.last = (state_reg == mdnf_pkg::EM_DONE);
        if (state_reg == mdnf_pkg::EM_EMPTY)
        begin
            push_res = '0;
            push_res.last = 1'b1;
            push_res.ovf = grp.ovf;
        end
    end

    // One-word output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else if (op_push)
            held_reg <= 1'b1;
        else if (res_ready)
            held_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (op_push)
            held_res <= push_res;
    end

    assign res_valid = held_reg;
    assign res = held_res;
endmodule

// ===== rtl/mdnf_store.sv =====
// Entry memory: one write port, one registered read port.
module mdnf_store (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [mdnf_pkg::IDX_W-1:0] wr_addr,
    input  logic [71:0]         wr_word,
    input  logic [mdnf_pkg::IDX_W-1:0] rd_addr,
    output logic [71:0]         rd_word
);
    logic [71:0] mem [mdnf_pkg::MAX_NEIGHBORS];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_word;
        rd_word <= mem[rd_addr];
    end
endmodule

// ===== rtl/minimum_distance_neighbor_filter_top.sv =====
// Top level of the minimum-distance neighbor filter.
//  channel  | dir | fields
//  s_axis   | in  | tdata: site, image a, b, c, dist_sq; tlast: last_entry
//  m_axis   | out | tdata: site, images, weight, valid, overflowed; tlast: last_result
//  apb      | in  | tolerance at 0x0, all_sites_mode at 0x4
// Loading takes one entry per cycle unless stalled; the group closes with the last word.
// Emission reads and tests each entry (READ, WAIT, TEST); a selected one then passes
// a 64-step divider and 32-step square root (minimum mode) or the root alone (all-sites).
// A result word is staged until the next one is selected or the group closes.
// Input stalls from the last word until the last result enters (empty group: leaves) the output reg.
// Reset clears counts, state and flags; the entry memory and datapath are not cleared.
`include "assert_macros.svh"
module minimum_distance_neighbor_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: neighbor_site[15:0], image_a[23:16], image_b[31:24], image_c[39:32],
    // dist_sq[71:40]
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_site[15:0], out_image_a[23:16], out_image_b[31:24],
    // out_image_c[39:32], weight[63:40], valid_neighbor[64], overflowed[65]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [17:0] tol_reg;
    logic mode_reg;
    logic wr_en, grp_valid, grp_take, res_valid;
    logic [mdnf_pkg::IDX_W-1:0] wr_addr, rd_addr;
    logic [71:0] wr_word, rd_word, in_word;
    mdnf_pkg::group_t grp;
    mdnf_pkg::result_t res;

    assign pready = 1'b1;
    // Register file writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= mdnf_pkg::TOL_RESET;
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == mdnf_pkg::ADDR_TOL)
                tol_reg <= pwdata[17:0];
            else
                mode_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == mdnf_pkg::ADDR_MODE && paddr[1:0] == 2'b00) ?
        {31'd0, mode_reg} : ((paddr == 3'd0) ? {14'd0, tol_reg} : 32'd0);

    // Memory word: dist_sq over site and image bytes.
    assign in_word = {s_axis_tdata[71:40], s_axis_tdata[15:0], s_axis_tdata[23:16],
        s_axis_tdata[31:24], s_axis_tdata[39:32]};

    mdnf_loader u_loader (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_word(in_word), .in_last(s_axis_tlast), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_word(wr_word), .grp_valid(grp_valid), .grp(grp), .grp_take(grp_take)
    );

    mdnf_store u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_word(wr_word),
        .rd_addr(rd_addr), .rd_word(rd_word)
    );

    mdnf_emitter u_emitter (
        .clk(clk), .rst_n(rst_n), .grp_valid(grp_valid), .grp(grp), .grp_take(grp_take),
        .rd_addr(rd_addr), .rd_word(rd_word), .tolerance(tol_reg),
        .all_sites_mode(mode_reg), .res_valid(res_valid), .res(res),
        .res_ready(m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata = {6'd0, res.ovf, res.valid_nb, res.weight, res.ic, res.ib,
        res.ia, res.site};
    assign m_axis_tlast = res.last;

    // Checks.
    `ASSERT_IMPL(a_no_load_while_emit, clk, rst_n, grp_valid, !s_axis_tready)
    `ASSERT_IMPL(a_invalid_is_last, clk, rst_n, m_axis_tvalid && !m_axis_tdata[64],
        m_axis_tlast)
    `ASSERT_NEXT(a_take_frees_input, clk, rst_n, grp_take, s_axis_tready)
endmodule

// ===== tb/tb_minimum_distance_neighbor_filter_top.sv =====
// Self-checking testbench of the neighbor filter: streams groups, predicts every word.
module tb_minimum_distance_neighbor_filter_top;
    localparam logic [2:0] REG_TOLERANCE = 3'd0;
    localparam logic [2:0] REG_ALL_SITES = 3'd4;
    localparam int         DEPTH         = mdnf_pkg::MAX_NEIGHBORS;
    localparam int         LONG_HOLD     = 700;

    // One candidate neighbor word plus testbench control.
    typedef struct {
        logic [15:0] site;
        logic [7:0]  ia;
        logic [7:0]  ib;
        logic [7:0]  ic;
        logic [31:0] dist_sq;
        logic        last;
        bit          drain_first;
    } neighbor_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    minimum_distance_neighbor_filter_top dut (.*);

    // Clock with period 20.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    neighbor_t           pending_q[$];
    mdnf_pkg::result_t   selected_q[$];
    int          errors = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          groups_closed = 0;
    int          empty_groups = 0;
    int          overflow_groups = 0;
    bit          quiet = 0;
    bit          hold_req = 0;

    // Predictor state: buffered group and copied registers.
    logic [39:0] grp_site_image[DEPTH];
    logic [31:0] grp_dist_sq[DEPTH];
    int          grp_count = 0;
    logic [31:0] grp_min = 32'hFFFF_FFFF;
    logic        grp_ovf = 1'b0;
    logic [17:0] cfg_tolerance = mdnf_pkg::TOL_RESET;
    logic        cfg_all_sites = 1'b0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Buffer one accepted word; on the last word queue the selected neighbors.
    task automatic select_neighbors(neighbor_t e);
        logic [31:0] eff;
        logic [39:0] f;
        logic [95:0] lhs;
        logic [95:0] rhs;
        logic [63:0] w;
        mdnf_pkg::result_t r;
        int          n;
        if (grp_count < DEPTH)
        begin
            eff = (e.dist_sq == 32'd0) ? mdnf_pkg::SELF_SUBST : e.dist_sq;
            grp_site_image[grp_count] = {e.site, e.ia, e.ib, e.ic};
            grp_dist_sq[grp_count] = e.dist_sq;
            grp_count++;
            if (eff < grp_min)
                grp_min = eff;
        end
        else
            grp_ovf = 1'b1;
        if (!e.last)
            return;
        f = 40'd65536 + cfg_tolerance;
        n = 0;
        for (int i = 0; i < grp_count; i++)
        begin
            if (grp_dist_sq[i] == 32'd0)
                continue;
            if (cfg_all_sites)
                w = int_sqrt({16'd0, grp_dist_sq[i], 16'd0});
            else
            begin
                lhs = {32'd0, grp_dist_sq[i], 32'd0};
                rhs = 96'(f) * 96'(f) * 96'(grp_min);
                if (!(lhs < rhs))
                    continue;
                w = int_sqrt({grp_min, 32'd0} / {32'd0, grp_dist_sq[i]});
            end
            r.site = grp_site_image[i][39:24];
            r.ia = grp_site_image[i][23:16];
            r.ib = grp_site_image[i][15:8];
            r.ic = grp_site_image[i][7:0];
            r.weight = w[23:0];
            r.valid_nb = 1'b1;
            r.ovf = grp_ovf;
            r.last = 1'b0;
            selected_q.insert(selected_q.size(), r);
            n++;
        end
        if (n == 0)
        begin
            r = '0;
            r.ovf = grp_ovf;
            selected_q.insert(selected_q.size(), r);
            empty_groups++;
        end
        selected_q[selected_q.size() - 1].last = 1'b1;
        if (grp_ovf)
            overflow_groups++;
        groups_closed++;
        grp_count = 0;
        grp_min = 32'hFFFF_FFFF;
        grp_ovf = 1'b0;
    endtask

    // Input driver: offers pending words with random gaps.
    int  in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        bit offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                select_neighbors(pending_q.pop_front());
                words_sent++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && selected_q.size() != 0))
                begin
                    if (!quiet && $urandom_range(0, 7) == 0)
                        in_gap = $urandom_range(1, 17);
                    else
                        offer = 1'b1;
                end
            end
            if (offer)
            begin
                s_axis_tdata <= {pending_q[0].dist_sq, pending_q[0].ic, pending_q[0].ib,
                                 pending_q[0].ia, pending_q[0].site};
                s_axis_tlast <= pending_q[0].last;
            end
            s_axis_tvalid <= offer;
        end
    end

    // Output monitor: random backpressure, one long hold, checks each result word.
    int  out_stall = 0;
    int  hold_cnt = 0;
    always @(posedge clk or negedge rst_n)
    begin
        mdnf_pkg::result_t got;
        mdnf_pkg::result_t want;
        logic    rdy;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.site = m_axis_tdata[15:0];
                got.ia = m_axis_tdata[23:16];
                got.ib = m_axis_tdata[31:24];
                got.ic = m_axis_tdata[39:32];
                got.weight = m_axis_tdata[63:40];
                got.valid_nb = m_axis_tdata[64];
                got.ovf = m_axis_tdata[65];
                got.last = m_axis_tlast;
                if (selected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = selected_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: expected site %h img %h %h %h w %h v %b o %b l %b",
                                 $time, want.site, want.ia, want.ib, want.ic, want.weight,
                                 want.valid_nb, want.ovf, want.last);
                        $display("%0t: actual   site %h img %h %h %h w %h v %b o %b l %b",
                                 $time, got.site, got.ia, got.ib, got.ic, got.weight,
                                 got.valid_nb, got.ovf, got.last);
                    end
                    words_checked++;
                end
            end
            if (hold_req)
            begin
                hold_cnt = LONG_HOLD;
                hold_req = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall--;
                rdy = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall = $urandom_range(1, 17) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            m_axis_tready <= rdy;
        end
    end

    task automatic add_word(logic [15:0] site, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                            logic [31:0] d, logic last, bit drain = 0);
        neighbor_t e;
        e.site = site;
        e.ia = a;
        e.ib = b;
        e.ic = c;
        e.dist_sq = d;
        e.last = last;
        e.drain_first = drain;
        pending_q.insert(pending_q.size(), e);
    endtask

    // Random group: distances clustered near a base so the threshold matters.
    task automatic add_group(int n, bit drain = 0);
        logic [63:0] base;
        logic [63:0] d;
        int          pick;
        base = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(1, 1 << 24));
        if (base == 0)
            base = 1;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                d = 0;
            else if (pick == 1)
                d = 64'($urandom);
            else
                d = base + 64'($urandom) % ((base >> $urandom_range(2, 6)) + 1);
            if (d > 64'hFFFF_FFFF)
                d = 64'hFFFF_FFFF;
            add_word(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), d[31:0],
                     i == n - 1, drain && i == 0);
        end
    endtask

    task automatic random_phase(int words);
        int start;
        start = pending_q.size();
        while (pending_q.size() - start < words)
        begin
            if ($urandom_range(0, 11) == 0)
                add_group($urandom_range(60, 70));
            else
                add_group($urandom_range(1, 10));
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || selected_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_TOLERANCE)
            cfg_tolerance = value[17:0];
        else
            cfg_all_sites = value[0];
    endtask

    // Timeout.
    initial
    begin
        #20000000;
        $display("minimum_distance_neighbor_filter_top regression: fail");
        $finish;
    end

    // Sequence of phases.
    initial
    begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, self entries, threshold edge, empty groups.
        add_word(16'h0000, 8'h80, 8'h80, 8'h80, 32'd1, 1'b0);
        add_word(16'hFFFF, 8'h7F, 8'h7F, 8'h7F, 32'hFFFF_FFFF, 1'b0);
        add_word(16'h1234, 8'h01, 8'hFF, 8'h00, 32'd0, 1'b0);
        add_word(16'h4321, 8'h55, 8'hAA, 8'h0F, 32'd2, 1'b0);
        add_word(16'hA5A5, 8'hF0, 8'h3C, 8'hC3, 32'd1, 1'b1);
        add_word(16'h0001, 8'h00, 8'h00, 8'h00, 32'd0, 1'b1);
        add_word(16'hBEEF, 8'h12, 8'h34, 8'h56, 32'hFFFF_FFFF, 1'b1);
        add_word(16'h0100, 8'h01, 8'h02, 8'h03, 32'd65536, 1'b0);
        add_word(16'h0101, 8'h04, 8'h05, 8'h06, 32'd79299, 1'b0);
        add_word(16'h0102, 8'h07, 8'h08, 8'h09, 32'd79300, 1'b0);
        add_word(16'h0103, 8'h0A, 8'h0B, 8'h0C, 32'd79301, 1'b1);
        add_word(16'h0200, 8'h00, 8'h00, 8'h00, 32'd0, 1'b0);
        add_word(16'h0201, 8'h00, 8'h00, 8'h00, 32'd0, 1'b0);
        add_word(16'h0202, 8'hFE, 8'h02, 8'h7E, 32'd5, 1'b1);
        add_word(16'h0300, 8'h11, 8'h22, 8'h33, mdnf_pkg::SELF_SUBST + 32'd1, 1'b0);
        add_word(16'h0301, 8'h44, 8'h55, 8'h66, 32'd0, 1'b1);
        wait_drained();

        // Zero tolerance: equal distances never qualify.
        reg_write(REG_TOLERANCE, 32'd0);
        add_word(16'h0400, 8'h01, 8'h01, 8'h01, 32'd4096, 1'b0);
        add_word(16'h0401, 8'h02, 8'h02, 8'h02, 32'd4096, 1'b1);
        random_phase(40);
        wait_drained();

        // Largest tolerance with a long receiver hold and a full buffer.
        reg_write(REG_TOLERANCE, 32'h0003_FFFF);
        @(negedge clk);
        hold_req = 1;
        add_group(64);
        add_group(65);
        add_group(70);
        random_phase(30);
        wait_drained();

        // All-sites mode.
        reg_write(REG_ALL_SITES, 32'd1);
        random_phase(30);
        add_group(4, 1);
        random_phase(30);
        wait_drained();

        // Random tolerance, minimum mode.
        reg_write(REG_ALL_SITES, 32'd0);
        reg_write(REG_TOLERANCE, $urandom_range(0, 262143));
        random_phase(50);
        wait_drained();

        // Default tolerance, no idling.
        reg_write(REG_TOLERANCE, 32'(mdnf_pkg::TOL_RESET));
        @(negedge clk);
        quiet = 1;
        random_phase(50);
        wait_drained();
        repeat (50) @(posedge clk);

        $display("Sent %0d neighbor words in %0d groups, checked %0d result words.",
                 words_sent, groups_closed, words_checked);
        $display("Groups with no neighbor: %0d, groups with dropped entries: %0d.",
                 empty_groups, overflow_groups);
        if (errors == 0 && selected_q.size() == 0)
            $display("minimum_distance_neighbor_filter_top regression: pass");
        else
            $display("minimum_distance_neighbor_filter_top regression: fail");
        $finish;
    end
endmodule

// ===== minimum_distance_neighbor_filter_top.f =====
+incdir+rtl
rtl/mdnf_pkg.sv
rtl/mdnf_loader.sv
rtl/mdnf_emitter.sv
rtl/mdnf_store.sv
rtl/minimum_distance_neighbor_filter_top.sv
tb/tb_minimum_distance_neighbor_filter_top.sv
